### hw/rtl/ngic_pkg.sv
// ----------------------------------------------------------------------------
// ngic_pkg: shared types and constants of the grid index converter
// Field widths, operation codes, register indexes and the item record
// that travels down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ngic_pkg;

    localparam int MAX_DIMS  = 4;
    localparam int LEN_BITS  = 12;
    localparam int IDX_BITS  = 48;
    localparam int CRD_BITS  = 14;
    localparam int NDIM_BITS = 3;
    localparam int DIM_W     = $clog2(MAX_DIMS);
    localparam int OP_BITS   = 2;

    // one division step per quotient bit, one group of cells per dimension
    localparam int DIV_CELLS = MAX_DIMS * IDX_BITS;

    localparam logic [OP_BITS-1:0] OP_LIN   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_DELIN = 2'd1;
    localparam logic [OP_BITS-1:0] OP_REL   = 2'd2;
    localparam logic [OP_BITS-1:0] OP_UNDEF = 2'd3;

    localparam logic [2:0] REG_NUM_DIMS = 3'd0;
    localparam logic [2:0] REG_LEN_0    = 3'd1;
    localparam logic [2:0] REG_LEN_1    = 3'd2;
    localparam logic [2:0] REG_LEN_2    = 3'd3;
    localparam logic [2:0] REG_LEN_3    = 3'd4;

    typedef struct packed {
        logic [OP_BITS-1:0]                 op;
        logic [IDX_BITS-1:0]                lin;   // index as received
        logic [MAX_DIMS-1:0][CRD_BITS-1:0]  off;   // coordinates or offsets
        logic [MAX_DIMS-1:0][LEN_BITS-1:0]  dc;    // delinearized coordinates
        logic [IDX_BITS-1:0]                quo;   // dividend, quotient bits shift in
        logic [LEN_BITS-1:0]                rem;   // partial remainder
        logic [IDX_BITS-1:0]                acc;   // relinearized index
        logic                               ok;    // all coordinates in range
    } item_t;

endpackage

`default_nettype wire

### hw/rtl/nd_grid_index_converter_top.sv
// ----------------------------------------------------------------------------
// nd_grid_index_converter_top: row-major grid index converter
// Linearize, delinearize and relative-neighbor operations on a grid of up
// to four dimensions, with an APB register port for the grid shape.
// ----------------------------------------------------------------------------
// The block takes one transfer per cycle and returns one result per item,
// in order: the item passes 197 register stages, the first loaded on the
// accepting edge: 192 restoring-division cells (48 per dimension, fastest
// dimension first) split the index into coordinates, four Horner cells
// rebuild the index, and an output register holds the result. A stalled
// output holds the whole chain. After a length register write the element
// count used for error results passes the product and count registers.
`default_nettype none

module nd_grid_index_converter_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,  // linear_index, coord_0, coord_1, coord_2, coord_3
    input  wire logic [1:0]   s_tuser,  // operation
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,  // result_index, out_coord_0 .. out_coord_3
    output logic [0:0]        m_tuser,  // out_of_range
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int ND  = ngic_pkg::MAX_DIMS;
    localparam int LB  = ngic_pkg::LEN_BITS;
    localparam int IB  = ngic_pkg::IDX_BITS;
    localparam int CB  = ngic_pkg::CRD_BITS;
    localparam int NDC = ngic_pkg::DIV_CELLS;

    // ---------------- registers ----------------
    logic [ngic_pkg::NDIM_BITS-1:0] num_dims_reg;
    logic [ND-1:0][LB-1:0]          len_reg;
    logic [2:0]                     reg_sel;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg <= ngic_pkg::NDIM_BITS'(1);
            for (int d = 0; d < ND; d++) begin
                len_reg[d] <= LB'(1);
            end
        end else if (wr_en) begin
            unique case (reg_sel)
                ngic_pkg::REG_NUM_DIMS: num_dims_reg <= pwdata[ngic_pkg::NDIM_BITS-1:0];
                ngic_pkg::REG_LEN_0:    len_reg[0]   <= pwdata[LB-1:0];
                ngic_pkg::REG_LEN_1:    len_reg[1]   <= pwdata[LB-1:0];
                ngic_pkg::REG_LEN_2:    len_reg[2]   <= pwdata[LB-1:0];
                ngic_pkg::REG_LEN_3:    len_reg[3]   <= pwdata[LB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            ngic_pkg::REG_NUM_DIMS: prdata[ngic_pkg::NDIM_BITS-1:0] = num_dims_reg;
            ngic_pkg::REG_LEN_0:    prdata[LB-1:0] = len_reg[0];
            ngic_pkg::REG_LEN_1:    prdata[LB-1:0] = len_reg[1];
            ngic_pkg::REG_LEN_2:    prdata[LB-1:0] = len_reg[2];
            ngic_pkg::REG_LEN_3:    prdata[LB-1:0] = len_reg[3];
            default: ;
        endcase
    end

    // dimensions in use, unused ones act as length 1
    logic [ngic_pkg::NDIM_BITS-1:0] n_use;
    logic [ND-1:0]                  in_use;
    logic [ND-1:0][LB-1:0]          len_eff;
    logic                           zero_len;

    always_comb begin
        n_use = num_dims_reg;
        if (num_dims_reg == '0) n_use = ngic_pkg::NDIM_BITS'(1);
        if (num_dims_reg > ngic_pkg::NDIM_BITS'(ND)) n_use = ngic_pkg::NDIM_BITS'(ND);
        zero_len = 1'b0;
        for (int d = 0; d < ND; d++) begin
            in_use[d]  = ngic_pkg::NDIM_BITS'(d) < n_use;
            len_eff[d] = in_use[d] ? len_reg[d] : LB'(1);
            if (in_use[d] && len_reg[d] == '0) zero_len = 1'b1;
        end
    end

    // element count, two registered product levels
    logic [2*LB-1:0] prod_a_reg;
    logic [2*LB-1:0] prod_b_reg;
    logic [4*LB-1:0] total_full;
    logic [IB-1:0]   total_reg;

    assign total_full = prod_a_reg * prod_b_reg;

    always_ff @(posedge aclk) begin
        prod_a_reg <= len_eff[0] * len_eff[1];
        prod_b_reg <= len_eff[2] * len_eff[3];
        total_reg  <= total_full[IB-1:0];
    end

    // ---------------- cell chain ----------------
    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    ngic_pkg::item_t    in_item;

    always_comb begin
        in_item     = '0;
        in_item.op  = s_tuser;
        in_item.lin = s_tdata[IB-1:0];
        for (int d = 0; d < ND; d++) begin
            in_item.off[d] = s_tdata[IB + d*CB +: CB];
        end
        in_item.quo = s_tdata[IB-1:0];
        in_item.ok  = 1'b1;
    end

    logic [NDC-1:0]        dv_vld;
    ngic_pkg::item_t       dv_item [NDC];

    genvar k;
    generate
        for (k = 0; k < NDC; k++) begin : g_div
            localparam int DIM = ND - 1 - k / IB;
            localparam int BIT = k % IB;
            logic            c_vld;
            ngic_pkg::item_t c_item;

            if (k == 0) begin : g_first
                assign c_vld  = s_tvalid;
                assign c_item = in_item;
            end else if (BIT == 0) begin : g_bound
                // finished dimension: remainder is its coordinate
                always_comb begin
                    c_item             = dv_item[k-1];
                    c_item.dc[DIM + 1] = dv_item[k-1].rem;
                    c_item.rem         = '0;
                end
                assign c_vld = dv_vld[k-1];
            end else begin : g_mid
                assign c_vld  = dv_vld[k-1];
                assign c_item = dv_item[k-1];
            end

            ngic_div_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (en),
                .divisor  (len_eff[DIM]),
                .vld_in   (c_vld),
                .item_in  (c_item),
                .vld_out  (dv_vld[k]),
                .item_out (dv_item[k])
            );
        end
    endgenerate

    ngic_pkg::item_t lin_start;

    always_comb begin
        lin_start       = dv_item[NDC-1];
        lin_start.dc[0] = dv_item[NDC-1].rem;
    end

    logic [ND-1:0]   ln_vld;
    ngic_pkg::item_t ln_item [ND];

    generate
        for (k = 0; k < ND; k++) begin : g_lin
            logic            c_vld;
            ngic_pkg::item_t c_item;

            if (k == 0) begin : g_first
                assign c_vld  = dv_vld[NDC-1];
                assign c_item = lin_start;
            end else begin : g_mid
                assign c_vld  = ln_vld[k-1];
                assign c_item = ln_item[k-1];
            end

            ngic_lin_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (en),
                .dim_idx  (ngic_pkg::DIM_W'(k)),
                .in_use   (in_use[k]),
                .len      (len_eff[k]),
                .vld_in   (c_vld),
                .item_in  (c_item),
                .vld_out  (ln_vld[k]),
                .item_out (ln_item[k])
            );
        end
    endgenerate

    // ---------------- result ----------------
    ngic_pkg::item_t fin;
    logic            fin_ok;
    logic            in_grid;
    logic [IB-1:0]   res_idx;
    logic [95:0]     res_data;

    assign fin     = ln_item[ND-1];
    // index below the element count leaves no quotient after the last division
    assign in_grid = fin.quo == '0;

    always_comb begin
        unique case (fin.op)
            ngic_pkg::OP_LIN:   fin_ok = fin.ok;
            ngic_pkg::OP_DELIN: fin_ok = in_grid;
            ngic_pkg::OP_REL:   fin_ok = in_grid && fin.ok;
            default:            fin_ok = 1'b0;
        endcase
        if (zero_len) fin_ok = 1'b0;

        if (!fin_ok) res_idx = total_reg;
        else if (fin.op == ngic_pkg::OP_DELIN) res_idx = fin.lin;
        else res_idx = fin.acc;

        res_data = '0;
        res_data[IB-1:0] = res_idx;
        for (int d = 0; d < ND; d++) begin
            if (fin_ok && fin.op == ngic_pkg::OP_DELIN && in_use[d]) begin
                res_data[IB + d*LB +: LB] = fin.dc[d];
            end
        end
    end

    logic [95:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= ln_vld[ND-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= res_data;
            m_tuser_reg <= !fin_ok;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

### hw/rtl/ngic_div_cell.sv
// ----------------------------------------------------------------------------
// ngic_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the length
// when it fits and shifts the quotient bit in. Registered toward the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ngic_div_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [ngic_pkg::LEN_BITS-1:0] divisor,
    input  wire logic                          vld_in,
    input  wire ngic_pkg::item_t               item_in,
    output logic                               vld_out,
    output ngic_pkg::item_t                    item_out
);

    logic                            vld_reg;
    ngic_pkg::item_t                 item_reg;
    ngic_pkg::item_t                 item_next;
    logic [ngic_pkg::LEN_BITS:0]     shifted;
    logic [ngic_pkg::LEN_BITS:0]     diff;
    logic                            fits;

    always_comb begin
        shifted   = {item_in.rem, item_in.quo[ngic_pkg::IDX_BITS-1]};
        diff      = shifted - {1'b0, divisor};
        fits      = shifted >= {1'b0, divisor};
        item_next = item_in;
        item_next.rem = fits ? diff[ngic_pkg::LEN_BITS-1:0]
                             : shifted[ngic_pkg::LEN_BITS-1:0];
        item_next.quo = {item_in.quo[ngic_pkg::IDX_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign vld_out  = vld_reg;
    assign item_out = item_reg;

endmodule

`default_nettype wire

### hw/rtl/ngic_lin_cell.sv
// ----------------------------------------------------------------------------
// ngic_lin_cell: one Horner step of relinearization
// Forms the coordinate of its dimension, checks it against the length and
// folds it into the running index: acc = acc * len + coord.
// ----------------------------------------------------------------------------
`default_nettype none

module ngic_lin_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [ngic_pkg::DIM_W-1:0]    dim_idx,
    input  wire logic                          in_use,
    input  wire logic [ngic_pkg::LEN_BITS-1:0] len,
    input  wire logic                          vld_in,
    input  wire ngic_pkg::item_t               item_in,
    output logic                               vld_out,
    output ngic_pkg::item_t                    item_out
);

    localparam int XW = ngic_pkg::LEN_BITS + 4;
    localparam int PW = ngic_pkg::IDX_BITS + ngic_pkg::LEN_BITS;

    logic                             vld_reg;
    ngic_pkg::item_t                  item_reg;
    ngic_pkg::item_t                  item_next;
    logic [ngic_pkg::CRD_BITS-1:0]    off;
    logic [ngic_pkg::LEN_BITS-1:0]    base;
    logic [XW-1:0]                    x;
    logic                             x_ok;
    logic [ngic_pkg::LEN_BITS-1:0]    x_use;
    logic [ngic_pkg::LEN_BITS-1:0]    mult;
    logic [PW-1:0]                    prod;

    always_comb begin
        off  = item_in.off[dim_idx];
        base = (item_in.op == ngic_pkg::OP_LIN) ? '0 : item_in.dc[dim_idx];
        // two's complement add, sign in the top bit
        x    = {{(XW-ngic_pkg::LEN_BITS){1'b0}}, base}
             + {{(XW-ngic_pkg::CRD_BITS){off[ngic_pkg::CRD_BITS-1]}}, off};
        x_ok = !x[XW-1] && (x[XW-2:0] < {{(XW-1-ngic_pkg::LEN_BITS){1'b0}}, len});
        x_use = in_use ? x[ngic_pkg::LEN_BITS-1:0] : '0;
        mult  = in_use ? len : {{(ngic_pkg::LEN_BITS-1){1'b0}}, 1'b1};
        prod  = item_in.acc * mult;
        item_next     = item_in;
        item_next.acc = prod[ngic_pkg::IDX_BITS-1:0]
                      + {{(ngic_pkg::IDX_BITS-ngic_pkg::LEN_BITS){1'b0}}, x_use};
        item_next.ok  = item_in.ok && (!in_use || x_ok);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign vld_out  = vld_reg;
    assign item_out = item_reg;

endmodule

`default_nettype wire
